>>> hdl/priority_event_latch_idle_timer_top_defines.svh
// Assertion macros for the event latch and idle timer block.
`ifndef PRIORITY_EVENT_LATCH_IDLE_TIMER_TOP_DEFINES_SVH
`define PRIORITY_EVENT_LATCH_IDLE_TIMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PELIT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PELIT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PELIT_ASSERT(label, clk, rst, prop, msg)
`define PELIT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hdl/pelit_pkg.sv
// Shared types and codes for the event latch and idle timer block.
`timescale 1ns / 1ps

package pelit_pkg;

   localparam int EVENT_COUNT = 10;
   localparam int EVENT_BITS  = 4;
   localparam int TIME_BITS   = 32;

   localparam logic [EVENT_BITS-1:0] EV_WAKE = 4'd2;
   localparam logic [EVENT_BITS-1:0] EV_IDLE = 4'd9;

   localparam logic [1:0] REQ_RAISE    = 2'd0;
   localparam logic [1:0] REQ_POLL     = 2'd1;
   localparam logic [1:0] REQ_ACTIVITY = 2'd2;

   localparam logic [1:0] MS_OTHER = 2'd0;
   localparam logic [1:0] MS_SLEEP = 2'd1;
   localparam logic [1:0] MS_IDLE  = 2'd2;

   localparam logic [TIME_BITS-1:0] IDLE_TIMEOUT_RESET = 32'd60000;

   typedef logic [EVENT_COUNT-1:0] flags_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [EVENT_BITS-1:0] raise_event;
      logic [1:0]            machine_state;
      logic [TIME_BITS-1:0]  now_ms;
   } req_word_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] emitted_event;
   } rsp_word_type;

   typedef logic [TIME_BITS-1:0] csr_word_type;

   typedef struct packed {
      logic                  fire;
      logic [EVENT_BITS-1:0] event_code;
      flags_type             clear_mask;
      logic                  touch;
   } pick_type;

endpackage

>>> hdl/pelit_chan_if.sv
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps

interface pelit_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> hdl/priority_event_latch_idle_timer_top.sv
// Event latch with fixed-priority poll and idle timeout, top level.
//
// Accepts one request word per clock when not stalled. A word is held in an
// input register and resolved from there against the pending flags and the
// activity time; a poll that emits lands in the result register, so an event
// reaches rsp_ch via the input and result registers. The result register is
// the only throttle: while an emitted word waits unread, a following poll that
// would emit holds in the input register and the request side stalls behind it.
// Raises, activity notes and polls that emit nothing never wait on the result
// side. The idle limit is written through the csr channel, which is always
// ready out of reset.
`timescale 1ns / 1ps
`include "priority_event_latch_idle_timer_top_defines.svh"

module priority_event_latch_idle_timer_top
   import pelit_pkg::*;
(
   input logic     clock,
   input logic     reset,
   pelit_chan_if.sink   req_ch,
   pelit_chan_if.source rsp_ch,
   pelit_chan_if.sink   csr_ch
);

   req_word_type         item_ff;
   logic                 item_valid_ff, item_valid_in;
   flags_type            flags_ff, flags_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] limit_ff;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   pick_type  pick;
   flags_type raise_mask;
   logic      is_poll;
   logic      emit;
   logic      out_free;
   logic      go;
   logic      take;

   pelit_pick u_pick (
      .flags         (flags_ff),
      .machine_state (item_ff.machine_state),
      .now_ms        (item_ff.now_ms),
      .last_time     (last_ff),
      .limit         (limit_ff),
      .pick          (pick)
   );

   always_comb begin
      for (int i = 0; i < EVENT_COUNT; i++) begin
         raise_mask[i] = (item_ff.raise_event == EVENT_BITS'(i));
      end
   end

   assign is_poll  = (item_ff.req_type == REQ_POLL);
   assign emit     = is_poll && pick.fire;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign go       = item_valid_ff && (out_free || !emit);
   assign take     = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !reset && (!item_valid_ff || go);
   assign csr_ch.ready = !reset;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_ff;

   always_comb begin
      item_valid_in = take ? 1'b1 : (go ? 1'b0 : item_valid_ff);
      flags_in      = flags_ff;
      last_in       = last_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (go) begin
         unique case (item_ff.req_type)
            REQ_RAISE: begin
               flags_in = flags_ff | raise_mask;
            end
            REQ_POLL: begin
               flags_in = flags_ff & ~pick.clear_mask;
               if (pick.touch) begin
                  last_in = item_ff.now_ms;
               end
               if (pick.fire) begin
                  rsp_in.emitted_event = pick.event_code;
                  rsp_valid_in         = 1'b1;
               end
            end
            REQ_ACTIVITY: begin
               last_in = item_ff.now_ms;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
         last_ff       <= '0;
         limit_ff      <= IDLE_TIMEOUT_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         flags_ff      <= flags_in;
         last_ff       <= last_in;
         if (csr_ch.valid) begin
            limit_ff <= csr_ch.word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_ch.word;
      end
      rsp_ff <= rsp_in;
   end

   // held request word must not change or vanish
   `PELIT_ASSERT(a_item_hold, clock, reset,
      item_valid_ff && !go |=> item_valid_ff && $stable(item_ff),
      "stalled request word lost")

   `PELIT_ASSERT(a_emit_touch, clock, reset,
      go && emit |=> last_ff == $past(item_ff.now_ms),
      "emission did not reset activity time")

   `PELIT_ASSERT(a_raise_sets, clock, reset,
      go && item_ff.req_type == REQ_RAISE |=>
         (flags_ff & $past(raise_mask)) == $past(raise_mask),
      "raised flag not pending")

   `PELIT_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_valid_ff && !item_valid_ff,
      "pipeline not empty after reset")

endmodule

>>> hdl/pelit_pick.sv
// Poll decision: priority pick over pending flags and idle timeout compare.
`timescale 1ns / 1ps

module pelit_pick
   import pelit_pkg::*;
(
   input  flags_type            flags,
   input  logic [1:0]           machine_state,
   input  logic [TIME_BITS-1:0] now_ms,
   input  logic [TIME_BITS-1:0] last_time,
   input  logic [TIME_BITS-1:0] limit,
   output pick_type             pick
);

   logic                  in_sleep;
   logic                  eligible;
   flags_type             usable;
   logic                  found;
   logic [EVENT_BITS-1:0] sel;
   logic [TIME_BITS-1:0]  elapsed;

   assign in_sleep = (machine_state == MS_SLEEP);
   assign eligible = (machine_state == MS_IDLE);
   assign elapsed  = now_ms - last_time;

   always_comb begin
      usable = flags;
      usable[EV_IDLE] = 1'b0;
      if (!in_sleep) begin
         usable[EV_WAKE] = 1'b0;
      end
      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < EVENT_COUNT; i++) begin
         if (!found && usable[i]) begin
            found = 1'b1;
            sel   = EVENT_BITS'(i);
         end
      end
   end

   always_comb begin
      pick = '0;
      priority if (found) begin
         pick.fire            = 1'b1;
         pick.event_code      = sel;
         pick.clear_mask[sel] = 1'b1;
         pick.touch           = 1'b1;
      end else if (flags[EV_IDLE]) begin
         // injected timeout always clears; only fires when idle-eligible
         pick.fire                = eligible;
         pick.event_code          = EV_IDLE;
         pick.clear_mask[EV_IDLE] = 1'b1;
         pick.touch               = eligible;
      end else if (eligible && (elapsed >= limit)) begin
         pick.fire       = 1'b1;
         pick.event_code = EV_IDLE;
         pick.touch      = 1'b1;
      end
   end

endmodule
